/* hw/rtl/spp_pkg.sv */
// Shared constants, types and fixed-point helpers for the solute phase partition block.
package spp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int W_F       = 17;
    localparam int W_T       = 20;
    localparam int W_C       = 24;
    localparam int W_P       = 44;
    localparam int W_D       = 18;
    localparam int Q_BITS    = 17;
    localparam int W_IDX     = 2;

    localparam logic [W_F-1:0] ONE_F = W_F'(ONE);
    localparam logic [W_P-1:0] HALF_P = W_P'(1) << (FRAC_BITS - 1);

    localparam logic [W_IDX-1:0] REG_CE    = 2'd0;
    localparam logic [W_IDX-1:0] REG_SLOPE = 2'd1;
    localparam logic [W_IDX-1:0] REG_KAPPA = 2'd2;
    localparam logic [W_IDX-1:0] REG_EDGE  = 2'd3;

    typedef struct packed {
        logic signed [W_C-1:0] c0_alt;
        logic                  sel_div;
        logic signed [W_C-1:0] c1;
        logic signed [W_C-1:0] c2;
        logic [W_F-1:0]        p0;
        logic [W_F-1:0]        p1;
        logic [W_F-1:0]        p2;
    } t_side;

    // round to nearest, ties away from zero, drop FRAC_BITS
    function automatic logic signed [W_P-1:0] rnd_shift(input logic signed [W_P-1:0] p);
        logic [W_P-1:0] mag;
        logic [W_P-1:0] r;
        mag = p[W_P-1] ? W_P'(-p) : W_P'(p);
        r   = (mag + HALF_P) >> FRAC_BITS;
        return p[W_P-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [W_F-1:0] sat_unit(input logic signed [W_P-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > $signed(W_P'(ONE))) begin
            return ONE_F;
        end
        return v[W_F-1:0];
    endfunction

    function automatic logic [W_F-1:0] sat_frac(input logic [W_F-1:0] v);
        return (v > ONE_F) ? ONE_F : v;
    endfunction

endpackage

/* hw/rtl/spp_front.sv */
// Front stages: equilibrium concentrations, phase products and divider operands.
module spp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [spp_pkg::W_F-1:0]      i_p0,
    input  logic [spp_pkg::W_F-1:0]      i_p1,
    input  logic [spp_pkg::W_F-1:0]      i_p2,
    input  logic [spp_pkg::W_F-1:0]      i_tot,
    input  logic signed [spp_pkg::W_T-1:0] i_temp,
    input  logic                         i_near,
    input  logic [spp_pkg::W_F-1:0]      i_ce,
    input  logic [spp_pkg::W_F-1:0]      i_slope,
    input  logic [spp_pkg::W_F-1:0]      i_kappa,
    input  logic [spp_pkg::W_F-1:0]      i_edge,
    output logic                         o_valid,
    output logic signed [spp_pkg::W_P-1:0] o_num,
    output logic [spp_pkg::W_D-1:0]      o_den,
    output spp_pkg::t_side               o_side
);
    import spp_pkg::*;

    // stage 1
    logic                  r1_v, r1_near;
    logic [W_F-1:0]        r1_p0, r1_p1, r1_p2, r1_tot;
    logic signed [W_C-1:0] r1_ts;
    logic signed [W_P-1:0] n1_prod;
    // stage 2
    logic                  r2_v, r2_near;
    logic [W_F-1:0]        r2_p0, r2_p1, r2_p2, r2_tot;
    logic signed [W_C-1:0] r2_cla, r2_clb, r2_csa, r2_csb;
    logic signed [W_C-1:0] n2_cla, n2_clb, n2_omc;
    logic signed [W_P-1:0] n2_pa, n2_pb;
    // stage 3
    logic                  r3_v, r3_near;
    logic [W_F-1:0]        r3_p0, r3_p1, r3_p2, r3_tot;
    logic signed [W_C-1:0] r3_csa, r3_csb;
    logic signed [W_P-1:0] r3_ma, r3_mb, r3_la, r3_lb;
    // stage 4
    logic signed [W_P-1:0] n4_num_i, n4_num_f;
    logic [W_D-1:0]        n4_den_f;
    logic                  n4_solid, n4_liquid, n4_fallback;
    logic                  r4_v;
    logic signed [W_P-1:0] r4_num;
    logic [W_D-1:0]        r4_den;
    t_side                 r4_side, n4_side;

    assign n1_prod = i_temp * $signed({1'b0, i_slope});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_p0   <= sat_frac(i_p0);
            r1_p1   <= sat_frac(i_p1);
            r1_p2   <= sat_frac(i_p2);
            r1_tot  <= i_tot;
            r1_near <= i_near;
            r1_ts   <= W_C'(rnd_shift(n1_prod));
        end
    end

    always_comb begin
        n2_cla = $signed({{(W_C-W_F){1'b0}}, i_ce}) - r1_ts;
        n2_clb = $signed({{(W_C-W_F){1'b0}}, i_ce}) + r1_ts;
        n2_omc = $signed(W_C'(ONE)) - n2_clb;
        n2_pa  = n2_cla * $signed({1'b0, i_kappa});
        n2_pb  = n2_omc * $signed({1'b0, i_kappa});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_p0   <= r1_p0;
            r2_p1   <= r1_p1;
            r2_p2   <= r1_p2;
            r2_tot  <= r1_tot;
            r2_near <= r1_near;
            r2_cla  <= n2_cla;
            r2_clb  <= n2_clb;
            r2_csa  <= W_C'(rnd_shift(n2_pa));
            r2_csb  <= $signed(W_C'(ONE)) - W_C'(rnd_shift(n2_pb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_p0   <= r2_p0;
            r3_p1   <= r2_p1;
            r3_p2   <= r2_p2;
            r3_tot  <= r2_tot;
            r3_near <= r2_near;
            r3_csa  <= r2_csa;
            r3_csb  <= r2_csb;
            r3_ma   <= r2_csa * $signed({1'b0, r2_p1});
            r3_mb   <= r2_csb * $signed({1'b0, r2_p2});
            r3_la   <= r2_cla * $signed({1'b0, r2_p1});
            r3_lb   <= r2_clb * $signed({1'b0, r2_p2});
        end
    end

    always_comb begin
        n4_num_i    = $signed(W_P'(r3_tot) << FRAC_BITS) - r3_ma - r3_mb;
        n4_num_f    = r3_la + r3_lb;
        n4_den_f    = W_D'(r3_p1) + W_D'(r3_p2);
        n4_solid    = (r3_p0 == '0);
        n4_liquid   = (r3_p0 == ONE_F);
        n4_fallback = !n4_solid && !n4_liquid && (r3_p0 < i_edge);

        n4_side.p0      = r3_p0;
        n4_side.p1      = r3_p1;
        n4_side.p2      = r3_p2;
        n4_side.c1      = r3_csa;
        n4_side.c2      = r3_csb;
        n4_side.c0_alt  = $signed({{(W_C-W_F){1'b0}}, r3_tot});
        n4_side.sel_div = !n4_solid && !n4_liquid && !(n4_fallback && n4_den_f == '0);
        if (n4_solid) begin
            n4_side.c0_alt = W_C'(rnd_shift(n4_num_f));
            if (!r3_near) begin
                if (r3_p1 == ONE_F) begin
                    n4_side.c1 = $signed({{(W_C-W_F){1'b0}}, r3_tot});
                end
                if (r3_p2 == ONE_F) begin
                    n4_side.c2 = $signed({{(W_C-W_F){1'b0}}, r3_tot});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            r4_num  <= n4_fallback ? n4_num_f : n4_num_i;
            r4_den  <= n4_fallback ? n4_den_f : W_D'(r3_p0);
            r4_side <= n4_side;
        end
    end

    assign o_valid = r4_v;
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

endmodule

/* hw/rtl/spp_div.sv */
// Pipelined restoring divider for the interface liquid concentration, one quotient bit a stage.
module spp_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [spp_pkg::W_P-1:0] i_num,
    input  logic [spp_pkg::W_D-1:0]        i_den,
    input  spp_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic signed [spp_pkg::W_C-1:0] o_c0,
    output spp_pkg::t_side                 o_side
);
    import spp_pkg::*;

    logic                r_v    [0:Q_BITS];
    logic [W_P-1:0]      r_rem  [0:Q_BITS];
    logic [Q_BITS-1:0]   r_q    [0:Q_BITS];
    logic [W_D-1:0]      r_den  [0:Q_BITS];
    logic                r_neg  [0:Q_BITS];
    logic                r_ovf  [0:Q_BITS];
    t_side               r_side [0:Q_BITS];

    logic [W_P-1:0]        n0_rem;
    logic                  r_vo;
    logic signed [W_C-1:0] r_c0, n_c0;
    t_side                 r_side_o;

    assign n0_rem = W_P'(i_num) + W_P'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= n0_rem;
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_neg[0]  <= i_num[W_P-1];
            r_ovf[0]  <= (n0_rem >= (W_P'(i_den) << Q_BITS));
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        localparam int BIT = Q_BITS - 1 - k;
        logic [W_P-1:0]    sub;
        logic              take;
        logic [Q_BITS-1:0] n_q;

        always_comb begin
            sub       = W_P'(r_den[k]) << BIT;
            take      = (r_rem[k] >= sub);
            n_q       = r_q[k];
            n_q[BIT]  = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= take ? (r_rem[k] - sub) : r_rem[k];
                r_q[k+1]    <= n_q;
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_comb begin
        if (!r_side[Q_BITS].sel_div) begin
            n_c0 = r_side[Q_BITS].c0_alt;
        end else if (r_neg[Q_BITS]) begin
            n_c0 = '0;
        end else if (r_ovf[Q_BITS] || r_q[Q_BITS] > ONE_F) begin
            n_c0 = W_C'(ONE);
        end else begin
            n_c0 = $signed({{(W_C-Q_BITS){1'b0}}, r_q[Q_BITS]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[Q_BITS];
        end
        if (i_en) begin
            r_c0     <= n_c0;
            r_side_o <= r_side[Q_BITS];
        end
    end

    assign o_valid = r_vo;
    assign o_c0    = r_c0;
    assign o_side  = r_side_o;

endmodule

/* hw/rtl/spp_total.sv */
// Back stages: saturated phase concentrations and the fraction-weighted total.
module spp_total (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [spp_pkg::W_C-1:0] i_c0,
    input  spp_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [spp_pkg::W_F-1:0]        o_conc_liquid,
    output logic [spp_pkg::W_F-1:0]        o_conc_solid_a,
    output logic [spp_pkg::W_F-1:0]        o_conc_solid_b,
    output logic [spp_pkg::W_F-1:0]        o_total_conc_new
);
    import spp_pkg::*;

    logic                  r1_v;
    logic signed [W_P-1:0] r1_m0, r1_m1, r1_m2;
    logic [W_F-1:0]        r1_c0, r1_c1, r1_c2;
    logic                  r2_v;
    logic [W_F-1:0]        r2_c0, r2_c1, r2_c2, r2_sum;
    logic signed [W_P-1:0] n2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_m0 <= i_c0 * $signed({1'b0, i_side.p0});
            r1_m1 <= i_side.c1 * $signed({1'b0, i_side.p1});
            r1_m2 <= i_side.c2 * $signed({1'b0, i_side.p2});
            r1_c0 <= sat_unit(W_P'(i_c0));
            r1_c1 <= sat_unit(W_P'(i_side.c1));
            r1_c2 <= sat_unit(W_P'(i_side.c2));
        end
    end

    assign n2_sum = r1_m0 + r1_m1 + r1_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_c0  <= r1_c0;
            r2_c1  <= r1_c1;
            r2_c2  <= r1_c2;
            r2_sum <= sat_unit(rnd_shift(n2_sum));
        end
    end

    assign o_valid          = r2_v;
    assign o_conc_liquid    = r2_c0;
    assign o_conc_solid_a   = r2_c1;
    assign o_conc_solid_b   = r2_c2;
    assign o_total_conc_new = r2_sum;

endmodule

/* hw/rtl/solute_phase_partition.sv */
// Top level of the solute phase partition pipeline.
//
// One voxel request enters on the s_axis channel: tdata carries the three phase
// fractions, the total concentration and the temperature; tuser carries the
// liquid-nearby flag. One result leaves on m_axis per request: liquid, solid A
// and solid B concentrations and the recomputed total, all saturated to [0,1].
// Four Q16 registers (eutectic concentration, inverse liquidus slope, partition
// coefficient, edge threshold) are written through i_cfg_we / i_cfg_index /
// i_cfg_data; write them only while the pipeline is empty, the block does not enforce it.
// Throughput is one request per cycle while m_axis is not stalled. From acceptance to
// m_axis_tvalid a request passes four front stages, one divider setup stage, 17 quotient-bit
// stages and its output stage, then a product stage and the output register.
// The 17-bit quotient of the liquid concentration sets the depth.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults. When the receiver holds m_axis_tready low with a result waiting,
// the whole pipeline freezes and s_axis_tready drops; while the output is empty
// requests keep flowing.
module solute_phase_partition (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [87:0]               s_axis_tdata,  // frac_liquid, frac_solid_a, frac_solid_b,
                                                     // total_conc, temperature
    input  logic                      s_axis_tuser,  // liquid_nearby
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [71:0]               m_axis_tdata,  // conc_liquid, conc_solid_a, conc_solid_b,
                                                     // total_conc_new, zero pad
    input  logic                      i_cfg_we,
    input  logic [spp_pkg::W_IDX-1:0] i_cfg_index,
    input  logic [spp_pkg::W_F-1:0]   i_cfg_data
);
    import spp_pkg::*;

    logic           en;
    logic [W_F-1:0] r_ce, r_slope, r_kappa, r_edge;

    logic                  f_v;
    logic signed [W_P-1:0] f_num;
    logic [W_D-1:0]        f_den;
    t_side                 f_side;
    logic                  d_v;
    logic signed [W_C-1:0] d_c0;
    t_side                 d_side;
    logic [W_F-1:0]        c0, c1, c2, tot_new;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ce    <= W_F'(32768);
            r_slope <= W_F'(6554);
            r_kappa <= W_F'(13107);
            r_edge  <= W_F'(3277);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CE:    r_ce    <= i_cfg_data;
                REG_SLOPE: r_slope <= i_cfg_data;
                REG_KAPPA: r_kappa <= i_cfg_data;
                REG_EDGE:  r_edge  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_p0    (s_axis_tdata[16:0]),
        .i_p1    (s_axis_tdata[33:17]),
        .i_p2    (s_axis_tdata[50:34]),
        .i_tot   (s_axis_tdata[67:51]),
        .i_temp  ($signed(s_axis_tdata[87:68])),
        .i_near  (s_axis_tuser),
        .i_ce    (r_ce),
        .i_slope (r_slope),
        .i_kappa (r_kappa),
        .i_edge  (r_edge),
        .o_valid (f_v),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    spp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_v),
        .o_c0    (d_c0),
        .o_side  (d_side)
    );

    spp_total u_total (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (d_v),
        .i_c0             (d_c0),
        .i_side           (d_side),
        .o_valid          (m_axis_tvalid),
        .o_conc_liquid    (c0),
        .o_conc_solid_a   (c1),
        .o_conc_solid_b   (c2),
        .o_total_conc_new (tot_new)
    );

    assign m_axis_tdata = {4'b0000, tot_new, c2, c1, c0};

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (c0 <= ONE_F && c1 <= ONE_F && c2 <= ONE_F && tot_new <= ONE_F))
        else $error("result concentration above one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(u_total.o_total_conc_new)))
        else $error("pipeline moved during stall");

endmodule

/* bench/tb_top.sv */
// Testbench for solute_phase_partition: directed table, then random voxels checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
    import spp_pkg::*;

    typedef struct {
        logic [16:0]        fl;
        logic [16:0]        fa;
        logic [16:0]        fb;
        logic [16:0]        tot;
        logic signed [19:0] temp;
        logic               near;
    } t_voxel;

    typedef struct {
        logic [16:0] cl;
        logic [16:0] ca;
        logic [16:0] cb;
        logic [16:0] tn;
    } t_conc;

    typedef struct {
        t_voxel v;
        bit     typed;
        t_conc  c;
    } t_row;

    localparam longint QONE = 65536;
    localparam int LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we = 0;
    logic [W_IDX-1:0] i_cfg_index = REG_CE;
    logic [W_F-1:0]   i_cfg_data = '0;

    solute_phase_partition uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    longint ce_q = 32768, slope_q = 6554, kappa_q = 13107, edge_q = 3277;
    t_conc  conc_pending[$];
    int     errors = 0;
    int     cycles = 0;
    bit     calm = 0;
    bit     stall_go = 0;

    function automatic longint q_round(longint p);
        if (p >= 0) return (p + 32768) >>> 16;
        return -((-p + 32768) >>> 16);
    endfunction

    function automatic longint div_near(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clamp_unit(longint v);
        return v < 0 ? 0 : (v > QONE ? QONE : v);
    endfunction

    function automatic longint frac_clip(logic [16:0] f);
        return f > QONE ? QONE : longint'(f);
    endfunction

    function automatic t_conc partition_solute(t_voxel v);
        longint p0, p1, p2, tot, t, ts, cla, clb, csa, csb, c0, c1, c2;
        t_conc r;
        p0 = frac_clip(v.fl);
        p1 = frac_clip(v.fa);
        p2 = frac_clip(v.fb);
        tot = longint'(v.tot);
        t = longint'(v.temp);
        ts = q_round(t * slope_q);
        cla = ce_q - ts;
        clb = ce_q + ts;
        csa = q_round(cla * kappa_q);
        csb = QONE - q_round((QONE - clb) * kappa_q);
        if (p0 == 0) begin
            c1 = (p1 == QONE) ? tot : csa;
            c2 = (p2 == QONE) ? tot : csb;
            if (v.near) begin
                c1 = csa;
                c2 = csb;
            end
            c0 = q_round(cla * p1 + clb * p2);
        end else if (p0 < QONE) begin
            c1 = csa;
            c2 = csb;
            c0 = div_near(tot * QONE - csa * p1 - csb * p2, p0);
            if (p0 < edge_q) begin
                if (p1 + p2 > 0) c0 = div_near(cla * p1 + clb * p2, p1 + p2);
                else c0 = tot;
            end
            c0 = clamp_unit(c0);
        end else begin
            c1 = csa;
            c2 = csb;
            c0 = tot;
        end
        r.tn = 17'(clamp_unit(q_round(c1 * p1 + c2 * p2 + c0 * p0)));
        r.cl = 17'(clamp_unit(c0));
        r.ca = 17'(clamp_unit(c1));
        r.cb = 17'(clamp_unit(c2));
        return r;
    endfunction

    function automatic logic [16:0] pick_frac();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return 17'(QONE);
            2: return 17'($urandom_range(1, 4000));
            3: return 17'($urandom_range(0, 17'h1FFFF));
            default: return 17'($urandom_range(0, QONE));
        endcase
    endfunction

    function automatic t_voxel random_voxel();
        t_voxel v;
        int rest;
        if ($urandom_range(99) < 60) begin
            v.fl = 17'($urandom_range(0, 2) == 0 ? $urandom_range(0, 5000)
                                                  : $urandom_range(0, QONE));
            rest = QONE - v.fl;
            v.fa = 17'($urandom_range(0, rest));
            v.fb = 17'(rest - v.fa);
        end else begin
            v.fl = pick_frac();
            v.fa = pick_frac();
            v.fb = pick_frac();
        end
        v.tot = 17'($urandom_range(0, 3) == 0 ? $urandom_range(0, 17'h1FFFF)
                                               : $urandom_range(0, QONE));
        v.temp = $urandom_range(0, 1) ? 20'($urandom_range(0, 20'hFFFFF))
                                      : 20'(int'($urandom_range(0, 20000)) - 10000);
        v.near = $urandom_range(0, 1);
        return v;
    endfunction

    task automatic send_voxel(t_voxel v, bit typed, t_conc c);
        while (!calm && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {v.temp, v.tot, v.fb, v.fa, v.fl};
        s_axis_tuser <= v.near;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        conc_pending.push_back(typed ? c : partition_solute(v));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (conc_pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [W_IDX-1:0] idx, logic [16:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
        case (idx)
            REG_CE:    ce_q = val;
            REG_SLOPE: slope_q = val;
            REG_KAPPA: kappa_q = val;
            default:   edge_q = val;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_conc e;
        t_conc a;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (m_axis_tvalid && m_axis_tready) begin
            a.cl = m_axis_tdata[16:0];
            a.ca = m_axis_tdata[33:17];
            a.cb = m_axis_tdata[50:34];
            a.tn = m_axis_tdata[67:51];
            if (conc_pending.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                e = conc_pending.pop_front();
                if (a.cl !== e.cl) begin
                    $error("conc_liquid exp %0d got %0d", e.cl, a.cl); errors++;
                end
                if (a.ca !== e.ca) begin
                    $error("conc_solid_a exp %0d got %0d", e.ca, a.ca); errors++;
                end
                if (a.cb !== e.cb) begin
                    $error("conc_solid_b exp %0d got %0d", e.cb, a.cb); errors++;
                end
                if (a.tn !== e.tn) begin
                    $error("total_conc_new exp %0d got %0d", e.tn, a.tn); errors++;
                end
            end
        end
    end

    // receiver: random backpressure, one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_go) begin
                stall_go = 0;
                m_axis_tready <= 0;
                repeat (300) @(negedge i_clk);
            end
            m_axis_tready <= calm || $urandom_range(99) >= 33;
        end
    end

    initial begin
        t_row rows[$];
        t_conc none;
        logic [16:0] cfg[6][4];
        none = '{0, 0, 0, 0};
        cfg = '{'{32768, 6554, 13107, 3277}, '{0, 0, 0, 0},
                '{65536, 65536, 65536, 65536}, '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF},
                '{0, 0, 0, 0}, '{40000, 20000, 50000, 10000}};
        for (int k = 0; k < 4; k++) cfg[4][k] = 17'($urandom_range(0, QONE));

        // fully solid, interface, fully liquid, fallback, saturation, extremes
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 6554, 58982, 0}});
        rows.push_back('{'{65536, 0, 0, 1000, 0, 0}, 1, '{1000, 6554, 58982, 1000}});
        rows.push_back('{'{17'h1FFFF, 0, 0, 1000, 0, 1}, 1, '{1000, 6554, 58982, 1000}});
        rows.push_back('{'{0, 65536, 0, 777, 0, 0}, 0, none});
        rows.push_back('{'{0, 0, 65536, 777, 0, 0}, 0, none});
        rows.push_back('{'{0, 65536, 0, 777, 0, 1}, 0, none});
        rows.push_back('{'{0, 32768, 32768, 40000, 20'sh10000, 0}, 0, none});
        rows.push_back('{'{0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 20'sh7FFFF, 1}, 0, none});
        rows.push_back('{'{32768, 16384, 16384, 30000, -20'sh8000, 0}, 0, none});
        rows.push_back('{'{1, 30000, 35535, 65536, 20'sh7FFFF, 0}, 0, none});
        rows.push_back('{'{100, 0, 0, 12345, 0, 1}, 0, none});
        rows.push_back('{'{3276, 31000, 31260, 5000, -20'sh80000, 0}, 0, none});
        rows.push_back('{'{3277, 31000, 31259, 5000, -20'sh80000, 1}, 0, none});
        rows.push_back('{'{65535, 1, 0, 0, 20'sh1, 0}, 0, none});
        rows.push_back('{'{40000, 17'h1FFFF, 0, 65536, 20'sh50000, 0}, 0, none});
        rows.push_back('{'{0, 0, 0, 17'h1FFFF, -20'sh1, 1}, 0, none});

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                write_reg(REG_CE, cfg[ph][0]);
                write_reg(REG_SLOPE, cfg[ph][1]);
                write_reg(REG_KAPPA, cfg[ph][2]);
                write_reg(REG_EDGE, cfg[ph][3]);
            end
            calm = (ph == 3);
            if (ph == 0)
                foreach (rows[i]) send_voxel(rows[i].v, rows[i].typed, rows[i].c);
            for (int n = 0; n < 130; n++) begin
                if (ph == 1 && n == 20) stall_go = 1;
                if (ph == 2 && n == 60) begin
                    s_axis_tvalid <= 0;
                    while (conc_pending.size() != 0) @(negedge i_clk);
                end
                send_voxel(random_voxel(), 0, none);
            end
        end
        drain();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/spp_pkg.sv
hw/rtl/spp_front.sv
hw/rtl/spp_div.sv
hw/rtl/spp_total.sv
hw/rtl/solute_phase_partition.sv
bench/tb_top.sv
